>>> rtl/i2c_register_master_top_defines.svh
// ----------------------------------------------------------------------------
// I2C register master assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_MASTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IRM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/irm_pkg.sv
// ----------------------------------------------------------------------------
// I2C register master package
// Types, codes, the bus operation list and small helper functions.
// ----------------------------------------------------------------------------
package irm_pkg;

   // Kind of an incoming transaction.
   typedef enum logic {
      ITEM_COMMAND = 1'b0,
      ITEM_TICK    = 1'b1
   } irm_item_kind_type;

   // Command codes.
   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_SELECT  = 2'd1,
      CMD_READ    = 2'd2,
      CMD_SET_BIT = 2'd3
   } irm_cmd_type;

   // Bus operations making up a transfer.
   typedef enum logic [3:0] {
      OP_START = 4'd0,
      OP_AW    = 4'd1,
      OP_AR    = 4'd2,
      OP_REG   = 4'd3,
      OP_DATA  = 4'd4,
      OP_ACK   = 4'd5,
      OP_GETB  = 4'd6,
      OP_NACK  = 4'd7,
      OP_STOP  = 4'd8
   } irm_op_type;

   localparam int unsigned PAUSE_W     = 10;
   localparam int unsigned OP_W        = 5;
   localparam logic [PAUSE_W-1:0] PAUSE_RESET = 10'd5;
   localparam logic [7:0] ADDR_WRITE  = 8'h40;
   localparam logic [7:0] ADDR_READ   = 8'h41;
   localparam logic [3:0] BYTE_BITS   = 4'd8;

   // Configuration port: word index bit and register index.
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam logic        CSR_IDX_PAUSE = 1'b0;

   // One classified input transaction.
   typedef struct packed {
      irm_item_kind_type kind;
      irm_cmd_type       command;
      logic [2:0]        device;
      logic [7:0]        register_index;
      logic [7:0]        write_data;
      logic [2:0]        bit_position;
      logic              bit_value;
      logic              sda_in;
   } irm_item_type;

   // One result transaction.
   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       nack_seen;
      logic       command_ignored;
   } irm_result_type;

   // Operation list shared by all commands.
   function automatic irm_op_type op_at(input logic [OP_W-1:0] idx);
      irm_op_type op;
      unique case (idx)
         5'd0, 5'd6, 5'd12:                 op = OP_START;
         5'd1, 5'd13:                       op = OP_AW;
         5'd7:                              op = OP_AR;
         5'd2, 5'd4, 5'd8, 5'd14, 5'd16,
         5'd18:                             op = OP_ACK;
         5'd3, 5'd15:                       op = OP_REG;
         5'd9:                              op = OP_GETB;
         5'd10:                             op = OP_NACK;
         5'd17:                             op = OP_DATA;
         default:                           op = OP_STOP;
      endcase
      return op;
   endfunction

   function automatic logic [OP_W-1:0] op_first(input irm_cmd_type cmd);
      logic [OP_W-1:0] idx;
      unique case (cmd)
         CMD_WRITE:  idx = 5'd12;
         CMD_READ:   idx = 5'd6;
         default:    idx = 5'd0;
      endcase
      return idx;
   endfunction

   function automatic logic [OP_W-1:0] op_end(input irm_cmd_type cmd);
      logic [OP_W-1:0] idx;
      unique case (cmd)
         CMD_SELECT: idx = 5'd6;
         CMD_READ:   idx = 5'd12;
         default:    idx = 5'd20;
      endcase
      return idx;
   endfunction

   // Index of the final phase of an operation.
   function automatic logic [1:0] last_phase(input irm_op_type op);
      logic [1:0] ph;
      unique case (op)
         OP_ACK, OP_GETB: ph = 2'd2;
         OP_STOP:         ph = 2'd3;
         default:         ph = 2'd1;
      endcase
      return ph;
   endfunction

   function automatic logic is_put_byte(input irm_op_type op);
      return (op == OP_AW) || (op == OP_AR) || (op == OP_REG) || (op == OP_DATA);
   endfunction

endpackage

>>> rtl/irm_front.sv
// ----------------------------------------------------------------------------
// I2C register master front end
// Accepts input transactions, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module irm_front import irm_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic         req_mode,
   input  logic [1:0]   req_command,
   input  logic [2:0]   req_device,
   input  logic [7:0]   req_register_index,
   input  logic [7:0]   req_write_data,
   input  logic [2:0]   req_bit_position,
   input  logic         req_bit_value,
   input  logic         req_sda_in,
   output irm_item_type item,
   output logic         item_valid,
   input  logic         item_take
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   irm_item_type         queue_mem [DEPTH];
   irm_item_type         item_class;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push_ok;
   logic                 pop_ok;

   // Classify the incoming transaction as a command or a time tick.
   always_comb begin
      item_class.kind           = req_mode ? ITEM_TICK : ITEM_COMMAND;
      item_class.command        = irm_cmd_type'(req_command);
      item_class.device         = req_device;
      item_class.register_index = req_register_index;
      item_class.write_data     = req_write_data;
      item_class.bit_position   = req_bit_position;
      item_class.bit_value      = req_bit_value;
      item_class.sda_in         = req_sda_in;
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign item_valid = (count_ff != '0);
   assign push_ok    = push && !full;
   assign pop_ok     = item_take && item_valid;
   assign item       = queue_mem[rd_ptr_ff];

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_mem[wr_ptr_ff] <= item_class;
      end
   end

endmodule

>>> rtl/irm_back.sv
// ----------------------------------------------------------------------------
// I2C register master back end
// Bus sequencer that executes one queued transaction per cycle while the
// result queue has room, and the result queue that holds its outputs until
// they are taken.
module irm_back import irm_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [PAUSE_W-1:0] pause_ticks,
   input  irm_item_type       item,
   input  logic               item_valid,
   output logic               item_take,
   output logic               empty,
   input  logic               pop,
   output irm_result_type     result
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   // Sequencer state.
   logic               busy_ff, busy_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [1:0]         phase_ff, phase_in;
   logic [PAUSE_W-1:0] pause_cnt_ff, pause_cnt_in;
   logic [3:0]         bit_cnt_ff, bit_cnt_in;
   logic [7:0]         shift_ff, shift_in;
   logic [7:0]         read_byte_ff, read_byte_in;
   logic [2:0]         held_device_ff, held_device_in;
   logic [7:0]         held_register_ff, held_register_in;
   logic [7:0]         held_data_ff, held_data_in;
   logic [2:0]         held_position_ff, held_position_in;
   logic               held_value_ff, held_value_in;
   irm_cmd_type        held_command_ff, held_command_in;
   logic               nack_ff, nack_in;
   logic               scl_level_ff, scl_level_in;
   logic               sda_level_ff, sda_level_in;

   // Intermediate values of one step.
   logic [PAUSE_W-1:0] pause_next;
   logic [PAUSE_W-1:0] pause_limit;
   irm_op_type         adv_kind;
   logic [OP_W-1:0]    adv_op;
   logic [1:0]         adv_phase;
   logic [3:0]         adv_bits;
   logic               adv_end;
   logic [7:0]         load_byte;
   logic [7:0]         bit_mask;
   logic [7:0]         get_byte;
   logic [3:0]         bits_inc;
   logic               done_now;
   logic               ignored_now;

   // Result queue.
   irm_result_type     rsp_mem [DEPTH];
   irm_result_type     result_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_full;
   logic               pop_ok;

   assign rsp_full  = (count_ff == CNT_W'(DEPTH));
   assign item_take = item_valid && !rsp_full;

   // Phase advance: next operation index, phase and bit count.
   always_comb begin
      adv_kind  = op_at(op_ff);
      adv_op    = op_ff;
      adv_phase = phase_ff;
      adv_bits  = bit_cnt_ff;
      adv_end   = 1'b0;
      if (phase_ff == last_phase(op_at(op_ff))) begin
         adv_phase = 2'd0;
         if (!((is_put_byte(op_at(op_ff)) || (op_at(op_ff) == OP_GETB)) &&
               (bit_cnt_ff < BYTE_BITS))) begin
            adv_bits = 4'd0;
            adv_op   = op_ff + 1'b1;
            adv_end  = (adv_op >= op_end(held_command_ff));
            adv_kind = op_at(adv_op);
         end
      end else begin
         adv_phase = phase_ff + 1'b1;
      end
   end

   // Byte to put on the bus at the start of a byte operation.
   always_comb begin
      bit_mask = 8'd1 << held_position_ff;
      unique case (adv_kind)
         OP_AW:   load_byte = ADDR_WRITE | {4'd0, held_device_ff, 1'b0};
         OP_AR:   load_byte = ADDR_READ | {4'd0, held_device_ff, 1'b0};
         OP_REG:  load_byte = held_register_ff;
         default: begin
            if (held_command_ff != CMD_SET_BIT) begin
               load_byte = held_data_ff;
            end else if (held_value_ff) begin
               load_byte = read_byte_ff | bit_mask;
            end else begin
               load_byte = read_byte_ff & ~bit_mask;
            end
         end
      endcase
   end

   assign pause_next  = pause_cnt_ff + 1'b1;
   assign pause_limit = (pause_ticks == '0) ? PAUSE_W'(1) : pause_ticks;
   assign get_byte    = {shift_ff[6:0], item.sda_in};
   assign bits_inc    = adv_bits + 1'b1;

   // One sequencer step for the transaction at the head of the queue.
   always_comb begin
      busy_in          = busy_ff;
      op_in            = op_ff;
      phase_in         = phase_ff;
      pause_cnt_in     = pause_cnt_ff;
      bit_cnt_in       = bit_cnt_ff;
      shift_in         = shift_ff;
      read_byte_in     = read_byte_ff;
      held_device_in   = held_device_ff;
      held_register_in = held_register_ff;
      held_data_in     = held_data_ff;
      held_position_in = held_position_ff;
      held_value_in    = held_value_ff;
      held_command_in  = held_command_ff;
      nack_in          = nack_ff;
      scl_level_in     = scl_level_ff;
      sda_level_in     = sda_level_ff;
      done_now         = 1'b0;
      ignored_now      = 1'b0;
      if (item_take) begin
         if (item.kind == ITEM_COMMAND) begin
            if (busy_ff) begin
               ignored_now = 1'b1;
            end else begin
               // A new command latches its fields and opens with a start.
               held_command_in  = item.command;
               held_device_in   = item.device;
               held_register_in = item.register_index;
               held_data_in     = item.write_data;
               held_position_in = item.bit_position;
               held_value_in    = item.bit_value;
               nack_in          = 1'b0;
               bit_cnt_in       = 4'd0;
               pause_cnt_in     = '0;
               op_in            = op_first(item.command);
               phase_in         = 2'd0;
               busy_in          = 1'b1;
               sda_level_in     = 1'b0;
            end
         end else if (busy_ff) begin
            if (pause_next >= pause_limit) begin
               pause_cnt_in = '0;
               if (adv_end) begin
                  busy_in    = 1'b0;
                  bit_cnt_in = 4'd0;
                  done_now   = 1'b1;
               end else begin
                  op_in      = adv_op;
                  phase_in   = adv_phase;
                  bit_cnt_in = adv_bits;
                  // Pin action on entry to the new phase.
                  unique case (adv_kind)
                     OP_START: begin
                        if (adv_phase == 2'd0) begin
                           sda_level_in = 1'b0;
                        end else begin
                           scl_level_in = 1'b0;
                        end
                     end
                     OP_STOP: begin
                        unique case (adv_phase)
                           2'd0:    scl_level_in = 1'b0;
                           2'd1:    sda_level_in = 1'b0;
                           2'd2:    scl_level_in = 1'b1;
                           default: sda_level_in = 1'b1;
                        endcase
                     end
                     default: begin
                        unique case (adv_phase)
                           2'd0: begin
                              scl_level_in = 1'b0;
                              if (adv_bits == 4'd0) begin
                                 if (is_put_byte(adv_kind)) begin
                                    shift_in = load_byte;
                                 end else if (adv_kind == OP_GETB) begin
                                    shift_in = 8'd0;
                                 end
                              end
                           end
                           2'd1: begin
                              if (is_put_byte(adv_kind)) begin
                                 sda_level_in = shift_ff[7];
                                 shift_in     = {shift_ff[6:0], 1'b0};
                                 bit_cnt_in   = bits_inc;
                              end else begin
                                 sda_level_in = 1'b1;
                              end
                              scl_level_in = 1'b1;
                           end
                           default: begin
                              if (adv_kind == OP_ACK) begin
                                 if (item.sda_in) begin
                                    nack_in = 1'b1;
                                 end
                              end else begin
                                 shift_in   = get_byte;
                                 bit_cnt_in = bits_inc;
                                 if (bits_inc >= BYTE_BITS) begin
                                    read_byte_in = get_byte;
                                 end
                              end
                           end
                        endcase
                     end
                  endcase
               end
            end else begin
               pause_cnt_in = pause_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         op_ff            <= '0;
         phase_ff         <= 2'd0;
         pause_cnt_ff     <= '0;
         bit_cnt_ff       <= 4'd0;
         shift_ff         <= 8'd0;
         read_byte_ff     <= 8'd0;
         held_device_ff   <= 3'd0;
         held_register_ff <= 8'd0;
         held_data_ff     <= 8'd0;
         held_position_ff <= 3'd0;
         held_value_ff    <= 1'b0;
         held_command_ff  <= CMD_WRITE;
         nack_ff          <= 1'b0;
         scl_level_ff     <= 1'b1;
         sda_level_ff     <= 1'b1;
      end else begin
         busy_ff          <= busy_in;
         op_ff            <= op_in;
         phase_ff         <= phase_in;
         pause_cnt_ff     <= pause_cnt_in;
         bit_cnt_ff       <= bit_cnt_in;
         shift_ff         <= shift_in;
         read_byte_ff     <= read_byte_in;
         held_device_ff   <= held_device_in;
         held_register_ff <= held_register_in;
         held_data_ff     <= held_data_in;
         held_position_ff <= held_position_in;
         held_value_ff    <= held_value_in;
         held_command_ff  <= held_command_in;
         nack_ff          <= nack_in;
         scl_level_ff     <= scl_level_in;
         sda_level_ff     <= sda_level_in;
      end
   end

   // Result of this step.
   always_comb begin
      result_in.scl_release     = scl_level_in;
      result_in.sda_release     = sda_level_in;
      result_in.busy_res        = busy_in;
      result_in.done_res        = done_now;
      result_in.read_data       = read_byte_in;
      result_in.nack_seen       = nack_in;
      result_in.command_ignored = ignored_now;
   end

   // Result queue pointers and fill level.
   assign empty  = (count_ff == '0);
   assign pop_ok = pop && !empty;
   assign result = rsp_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (item_take) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({item_take, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_mem[wr_ptr_ff] <= result_in;
      end
   end

endmodule

>>> rtl/i2c_register_master_top.sv
// I2C register master. Each input transaction is either a command or one
// time tick; every input transaction yields exactly one result transaction
// carrying the SCL/SDA release levels, busy and done flags, the last byte
// read and the acknowledge status. The block sustains one transaction per
// clock cycle while the result queue has room: an input transaction is
// written into a CMD_DEPTH-deep input queue, the bus sequencer takes the
// head of that queue and writes its result into an RSP_DEPTH-deep result
// queue. The sequencer step (pause counter compare, operation list lookup
// and shift register update) sets this rate. On the bus, each phase lasts
// pause_ticks ticks (zero counts as one). No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
// I2C register master top level
// Configuration registers and the front and back end of the bus master.
// ----------------------------------------------------------------------------
`include "i2c_register_master_top_defines.svh"

module i2c_register_master_top import irm_pkg::*; #(
   parameter int unsigned CMD_DEPTH = 4,
   parameter int unsigned RSP_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input transactions
   input  logic                  push,
   output logic                  full,
   input  logic                  req_mode,
   input  logic [1:0]            req_command,
   input  logic [2:0]            req_device,
   input  logic [7:0]            req_register_index,
   input  logic [7:0]            req_write_data,
   input  logic [2:0]            req_bit_position,
   input  logic                  req_bit_value,
   input  logic                  req_sda_in,
   // Result transactions
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_scl_release,
   output logic                  rsp_sda_release,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic [7:0]            rsp_read_data,
   output logic                  rsp_nack_seen,
   output logic                  rsp_command_ignored,
   // Configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [PAUSE_W-1:0] pause_ticks_ff, pause_ticks_in;
   logic               csr_write;
   irm_item_type       item;
   logic               item_valid;
   logic               item_take;
   irm_result_type     result;

   // Configuration register: pause length in ticks.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      pause_ticks_in = pause_ticks_ff;
      if (csr_write && (paddr[CSR_ADDR_W-1] == CSR_IDX_PAUSE)) begin
         pause_ticks_in = pwdata[PAUSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pause_ticks_ff <= PAUSE_RESET;
      end else begin
         pause_ticks_ff <= pause_ticks_in;
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_IDX_PAUSE) ?
                   {{(32 - PAUSE_W){1'b0}}, pause_ticks_ff} : 32'd0;

   // Front end: accept and classify.
   irm_front #(
      .DEPTH (CMD_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_mode           (req_mode),
      .req_command        (req_command),
      .req_device         (req_device),
      .req_register_index (req_register_index),
      .req_write_data     (req_write_data),
      .req_bit_position   (req_bit_position),
      .req_bit_value      (req_bit_value),
      .req_sda_in         (req_sda_in),
      .item               (item),
      .item_valid         (item_valid),
      .item_take          (item_take)
   );

   // Back end: bus sequencer and result queue.
   irm_back #(
      .DEPTH (RSP_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pause_ticks (pause_ticks_ff),
      .item        (item),
      .item_valid  (item_valid),
      .item_take   (item_take),
      .empty       (empty),
      .pop         (pop),
      .result      (result)
   );

   assign rsp_scl_release     = result.scl_release;
   assign rsp_sda_release     = result.sda_release;
   assign rsp_busy_res        = result.busy_res;
   assign rsp_done_res        = result.done_res;
   assign rsp_read_data       = result.read_data;
   assign rsp_nack_seen       = result.nack_seen;
   assign rsp_command_ignored = result.command_ignored;

   // An idle bus always has both lines released.
   `IRM_ASSERT_SAME(a_idle_released, clock, reset,
      !empty && !rsp_busy_res, rsp_scl_release && rsp_sda_release)
   // A finished transfer leaves the master idle.
   `IRM_ASSERT_SAME(a_done_idle, clock, reset, !empty && rsp_done_res, !rsp_busy_res)
   // A dropped command only happens during a transfer and never ends it.
   `IRM_ASSERT_SAME(a_ignored_busy, clock, reset,
      !empty && rsp_command_ignored, rsp_busy_res && !rsp_done_res)
   // Both queues come out of reset empty.
   `IRM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty && !full)

endmodule

>>> tb/irm_sequence_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register master transaction checker
// Watches the input and result queues and the configuration port, predicts
// the bus pin levels and status of every accepted input transaction, and
// compares each popped result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module irm_sequence_checker import irm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  logic                  req_mode,
   input  logic [1:0]            req_command,
   input  logic [2:0]            req_device,
   input  logic [7:0]            req_register_index,
   input  logic [7:0]            req_write_data,
   input  logic [2:0]            req_bit_position,
   input  logic                  req_bit_value,
   input  logic                  req_sda_in,
   input  logic                  empty,
   input  logic                  pop,
   input  logic                  rsp_scl_release,
   input  logic                  rsp_sda_release,
   input  logic                  rsp_busy_res,
   input  logic                  rsp_done_res,
   input  logic [7:0]            rsp_read_data,
   input  logic                  rsp_nack_seen,
   input  logic                  rsp_command_ignored,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    results_owed
);

   localparam logic [6:0]  STEP_IDLE = 7'd127;
   localparam int unsigned OP_COUNT  = 20;

   // Predicted state of the bus sequencer.
   logic [PAUSE_W-1:0] pause_ticks;
   logic [PAUSE_W-1:0] pause_cnt;
   logic [6:0]         step;
   logic [3:0]         bit_cnt;
   logic [7:0]         shifter;
   logic [7:0]         last_read;
   irm_cmd_type        cur_cmd;
   logic [2:0]         cur_device;
   logic [7:0]         cur_register;
   logic [7:0]         cur_data;
   logic [2:0]         cur_position;
   logic               cur_value;
   logic               nack_flag;
   logic               scl_level;
   logic               sda_level;

   irm_result_type expected_bus_states[$];
   int             failures;

   // Bus operation held at each position of the shared sequence.
   function automatic irm_op_type bus_op(input int unsigned idx);
      irm_op_type op;
      unique case (idx)
         0, 6, 12:            op = OP_START;
         1, 13:               op = OP_AW;
         7:                   op = OP_AR;
         3, 15:               op = OP_REG;
         17:                  op = OP_DATA;
         2, 4, 8, 14, 16, 18: op = OP_ACK;
         9:                   op = OP_GETB;
         10:                  op = OP_NACK;
         default:             op = OP_STOP;
      endcase
      return op;
   endfunction

   function automatic int unsigned first_op(input irm_cmd_type cmd);
      unique case (cmd)
         CMD_WRITE: return 12;
         CMD_READ:  return 6;
         default:   return 0;
      endcase
   endfunction

   function automatic int unsigned end_op(input irm_cmd_type cmd);
      unique case (cmd)
         CMD_SELECT: return 6;
         CMD_READ:   return 12;
         default:    return 20;
      endcase
   endfunction

   function automatic int unsigned phases_of(input irm_op_type op);
      unique case (op)
         OP_ACK, OP_GETB: return 3;
         OP_STOP:         return 4;
         default:         return 2;
      endcase
   endfunction

   function automatic logic sends_byte(input irm_op_type op);
      return (op == OP_AW) || (op == OP_AR) || (op == OP_REG) || (op == OP_DATA);
   endfunction

   // Byte shifted out by an operation; set bit writes back the byte just read.
   function automatic logic [7:0] outgoing_byte(input irm_op_type op);
      logic [7:0] mask;
      mask = 8'd1 << cur_position;
      unique case (op)
         OP_AW:   return ADDR_WRITE | {4'd0, cur_device, 1'b0};
         OP_AR:   return ADDR_READ | {4'd0, cur_device, 1'b0};
         OP_REG:  return cur_register;
         default: begin
            if (cur_cmd != CMD_SET_BIT) return cur_data;
            return cur_value ? (last_read | mask) : (last_read & ~mask);
         end
      endcase
   endfunction

   // Pin action taken on entry to a phase of an operation.
   function automatic void enter_phase(input irm_op_type op, input logic [1:0] phase,
                                       input logic sda);
      if (op == OP_START) begin
         if (phase == 2'd0) sda_level = 1'b0;
         else scl_level = 1'b0;
      end else if (op == OP_STOP) begin
         unique case (phase)
            2'd0:    scl_level = 1'b0;
            2'd1:    sda_level = 1'b0;
            2'd2:    scl_level = 1'b1;
            default: sda_level = 1'b1;
         endcase
      end else if (phase == 2'd0) begin
         scl_level = 1'b0;
         if (bit_cnt == 4'd0) begin
            if (sends_byte(op)) shifter = outgoing_byte(op);
            else if (op == OP_GETB) shifter = 8'd0;
         end
      end else if (phase == 2'd1) begin
         if (sends_byte(op)) begin
            sda_level = shifter[7];
            shifter   = {shifter[6:0], 1'b0};
            bit_cnt   = bit_cnt + 4'd1;
         end else begin
            sda_level = 1'b1;
         end
         scl_level = 1'b1;
      end else if (op == OP_ACK) begin
         if (sda) nack_flag = 1'b1;
      end else begin
         // Sample the data line after the clock high pause.
         shifter = {shifter[6:0], sda};
         bit_cnt = bit_cnt + 4'd1;
         if (bit_cnt >= BYTE_BITS) last_read = shifter;
      end
   endfunction

   // Step to the next phase; returns 1 when the whole sequence is over.
   function automatic logic advance_phase(input logic sda);
      int unsigned idx;
      int unsigned phase;
      irm_op_type  op;
      idx   = 32'(step >> 2);
      phase = 32'(step[1:0]);
      if (idx >= OP_COUNT) return 1'b1;
      op = bus_op(idx);
      phase++;
      if (phase >= phases_of(op)) begin
         phase = 0;
         if (!((sends_byte(op) || op == OP_GETB) && bit_cnt < BYTE_BITS)) begin
            bit_cnt = 4'd0;
            idx++;
            if (idx >= end_op(cur_cmd) || idx >= OP_COUNT) return 1'b1;
            op = bus_op(idx);
         end
      end
      step = 7'((idx << 2) | phase);
      enter_phase(op, 2'(phase), sda);
      return 1'b0;
   endfunction

   // Apply one input transaction to the predicted state and return its result.
   function automatic irm_result_type predict_bus_item(input irm_item_type it);
      irm_result_type res;
      logic           busy;
      int unsigned    limit;
      res  = '0;
      busy = (step != STEP_IDLE);
      if (it.kind == ITEM_COMMAND) begin
         if (busy) begin
            res.command_ignored = 1'b1;
         end else begin
            cur_cmd      = it.command;
            cur_device   = it.device;
            cur_register = it.register_index;
            cur_data     = it.write_data;
            cur_position = it.bit_position;
            cur_value    = it.bit_value;
            nack_flag    = 1'b0;
            bit_cnt      = 4'd0;
            pause_cnt    = '0;
            step         = 7'(first_op(cur_cmd) << 2);
            enter_phase(bus_op(first_op(cur_cmd)), 2'd0, it.sda_in);
         end
      end else if (busy) begin
         limit     = (pause_ticks == '0) ? 32'd1 : 32'(pause_ticks);
         pause_cnt = pause_cnt + 1'b1;
         if (pause_cnt >= limit) begin
            pause_cnt = '0;
            if (advance_phase(it.sda_in)) begin
               step         = STEP_IDLE;
               bit_cnt      = 4'd0;
               res.done_res = 1'b1;
            end
         end
      end
      res.scl_release = scl_level;
      res.sda_release = sda_level;
      res.busy_res    = (step != STEP_IDLE);
      res.read_data   = last_read;
      res.nack_seen   = nack_flag;
      return res;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                  $time, field, want, got);
      end
   endtask

   // Sample both queues and the configuration port at every rising edge.
   always @(posedge clock) begin : watch
      irm_item_type   item;
      irm_result_type got;
      irm_result_type want;
      if (reset) begin
         pause_ticks  = PAUSE_RESET;
         pause_cnt    = '0;
         step         = STEP_IDLE;
         bit_cnt      = 4'd0;
         shifter      = 8'd0;
         last_read    = 8'd0;
         cur_cmd      = CMD_WRITE;
         cur_device   = 3'd0;
         cur_register = 8'd0;
         cur_data     = 8'd0;
         cur_position = 3'd0;
         cur_value    = 1'b0;
         nack_flag    = 1'b0;
         scl_level    = 1'b1;
         sda_level    = 1'b1;
         failures     = 0;
         expected_bus_states.delete();
      end else begin
         if (psel && penable && pwrite && pready &&
             paddr[CSR_ADDR_W-1:2] == CSR_IDX_PAUSE)
            pause_ticks = pwdata[PAUSE_W-1:0];
         if (push && !full) begin
            item = {req_mode, req_command, req_device, req_register_index,
                    req_write_data, req_bit_position, req_bit_value, req_sda_in};
            expected_bus_states.push_back(predict_bus_item(item));
         end
         if (pop && !empty) begin
            got = {rsp_scl_release, rsp_sda_release, rsp_busy_res, rsp_done_res,
                   rsp_read_data, rsp_nack_seen, rsp_command_ignored};
            if (expected_bus_states.size() == 0) begin
               failures++;
               $display("%0t ns: result transaction with nothing expected, got 0x%0h",
                        $time, got);
            end else begin
               want = expected_bus_states.pop_front();
               check_field("scl_release", want.scl_release, got.scl_release);
               check_field("sda_release", want.sda_release, got.sda_release);
               check_field("busy_res", want.busy_res, got.busy_res);
               check_field("done_res", want.done_res, got.done_res);
               check_field("read_data", want.read_data, got.read_data);
               check_field("nack_seen", want.nack_seen, got.nack_seen);
               check_field("command_ignored", want.command_ignored, got.command_ignored);
            end
         end
      end
      mismatch_count <= failures;
      results_owed   <= expected_bus_states.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register master testbench
// Drives command and tick transactions into the block under several pause
// settings, pops results with random stalls, and reports the verdict of the
// checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb import irm_pkg::*; ();

   localparam int RUN_LIMIT_NS  = 1_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic                  req_mode = 1'b0;
   logic [1:0]            req_command = 2'd0;
   logic [2:0]            req_device = 3'd0;
   logic [7:0]            req_register_index = 8'd0;
   logic [7:0]            req_write_data = 8'd0;
   logic [2:0]            req_bit_position = 3'd0;
   logic                  req_bit_value = 1'b0;
   logic                  req_sda_in = 1'b0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic                  rsp_scl_release;
   logic                  rsp_sda_release;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic [7:0]            rsp_read_data;
   logic                  rsp_nack_seen;
   logic                  rsp_command_ignored;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = 32'd0;
   logic [31:0]           prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    results_owed;

   // Stimulus pacing shared with the helper tasks.
   logic        tx_quiet = 1'b0;
   int unsigned pace = 32'(PAUSE_RESET);
   int          stall_requests = 0;

   i2c_register_master_top i_dut (.*);

   irm_sequence_checker i_checker (.*);

   always #1 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT_NS);
      $display("i2c_register_master_top verification failed");
      $finish;
   end

   // Phases a complete command walks through on the bus.
   function automatic int unsigned full_phases(input irm_cmd_type cmd);
      unique case (cmd)
         CMD_WRITE:  return 63;
         CMD_SELECT: return 44;
         CMD_READ:   return 51;
         default:    return 158;
      endcase
   endfunction

   function automatic irm_item_type random_item(input irm_item_kind_type kind);
      irm_item_type it;
      it.kind           = kind;
      it.command        = irm_cmd_type'($urandom_range(0, 3));
      it.device         = 3'($urandom_range(0, 7));
      it.register_index = 8'($urandom_range(0, 255));
      it.write_data     = 8'($urandom_range(0, 255));
      it.bit_position   = 3'($urandom_range(0, 7));
      it.bit_value      = 1'($urandom_range(0, 1));
      it.sda_in         = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic irm_item_type command_item(input irm_cmd_type cmd,
                                                 input logic [2:0] device,
                                                 input logic [7:0] register_index,
                                                 input logic [7:0] write_data,
                                                 input logic [2:0] bit_position,
                                                 input logic bit_value);
      irm_item_type it;
      it                = random_item(ITEM_COMMAND);
      it.command        = cmd;
      it.device         = device;
      it.register_index = register_index;
      it.write_data     = write_data;
      it.bit_position   = bit_position;
      it.bit_value      = bit_value;
      return it;
   endfunction

   // Offer one input transaction after a random gap and wait for acceptance.
   task automatic send_item(input irm_item_type it);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push               <= 1'b1;
      req_mode           <= it.kind;
      req_command        <= it.command;
      req_device         <= it.device;
      req_register_index <= it.register_index;
      req_write_data     <= it.write_data;
      req_bit_position   <= it.bit_position;
      req_bit_value      <= it.bit_value;
      req_sda_in         <= it.sda_in;
      do @(posedge clock); while (full);
   endtask

   // Stop sending and let every predicted result come out.
   task automatic wait_for_results();
      push <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pause(input logic [PAUSE_W-1:0] ticks);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_IDX_PAUSE, 2'b00};
      pwdata  <= {{(32 - PAUSE_W){1'b0}}, ticks};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pace = (ticks == '0) ? 32'd1 : 32'(ticks);
   endtask

   // Commands followed by enough ticks to finish them, some cut short, with
   // the odd stray command landing while the bus is still busy.
   task automatic run_traffic(input int unsigned budget);
      irm_item_type it;
      int unsigned  sent;
      int unsigned  ticks;
      int unsigned  k;
      sent = 0;
      while (sent < budget) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         it = random_item(ITEM_COMMAND);
         send_item(it);
         sent++;
         ticks = full_phases(it.command) * pace + $urandom_range(0, 6);
         if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, ticks);
         for (k = 0; k < ticks && sent < budget; k++) begin
            if ($urandom_range(0, 24) == 0) it = random_item(ITEM_COMMAND);
            else it = random_item(ITEM_TICK);
            send_item(it);
            sent++;
         end
      end
      tx_quiet = 1'b0;
   endtask

   // Result side: pop with random gaps, quiet stretches and long hold-offs.
   initial begin : result_drain
      int   gap;
      int   stalls_served;
      logic rx_quiet;
      stalls_served = 0;
      rx_quiet      = 1'b0;
      @(negedge reset);
      forever begin
         if (stall_requests != stalls_served) begin
            stalls_served = stall_requests;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
         gap = rx_quiet ? 0 : $urandom_range(0, 11);
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   // Input side and verdict.
   initial begin : stimulus
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: ticks while idle, a set bit at the field extremes, commands
      // dropped while busy, then ticks with both data line levels.
      send_item(random_item(ITEM_TICK));
      send_item(random_item(ITEM_TICK));
      send_item(command_item(CMD_SET_BIT, 3'd7, 8'hFF, 8'h00, 3'd7, 1'b1));
      send_item(command_item(CMD_WRITE, 3'd0, 8'h00, 8'hFF, 3'd0, 1'b0));
      send_item(command_item(CMD_SELECT, 3'd7, 8'h00, 8'h00, 3'd7, 1'b0));
      send_item(command_item(CMD_READ, 3'd0, 8'hFF, 8'hFF, 3'd0, 1'b1));
      for (k = 0; k < 18; k++) send_item(random_item(ITEM_TICK));
      wait_for_results();

      // A zero pause counts as one tick; the results side is held off early on.
      write_pause('0);
      stall_requests++;
      run_traffic(200);
      wait_for_results();

      // A long pause: the counter runs well up before the bus moves on.
      write_pause(10'd100);
      tx_quiet = 1'b1;
      send_item(random_item(ITEM_COMMAND));
      for (k = 0; k < 130; k++) send_item(random_item(ITEM_TICK));
      tx_quiet = 1'b0;
      wait_for_results();

      write_pause(10'd1);
      stall_requests++;
      run_traffic(200);
      wait_for_results();

      write_pause(PAUSE_W'($urandom_range(2, 3)));
      run_traffic(150);
      wait_for_results();

      if (mismatch_count == 0) begin
         $display("i2c_register_master_top verification clean");
      end else begin
         $display("i2c_register_master_top verification failed");
      end
      $finish;
   end

endmodule
